[hdl/tgarle_pkg.sv]
// Shared types, constants and helpers for the TGA run-length packet decoder.
package tgarle_pkg;

  localparam logic [7:0] HDR_RAW_LIMIT = 8'h80;
  localparam logic [7:0] REPEAT_BIAS   = 8'd127;
  localparam logic [2:0] MAX_PIX_BYTES = 3'd4;
  localparam logic [2:0] PIX_BYTES_RST = 3'd3;

  localparam logic REG_PIXEL_BYTES = 1'b0;

  typedef enum logic {
    PH_HEADER,
    PH_PIXEL
  } phase_t;

  typedef struct packed {
    logic        packet_end;
    logic [7:0]  repeat_count;
    logic [31:0] pixel_value;
  } result_t;

  // zero acts as one, five to seven act as four
  function automatic logic [2:0] eff_size(input logic [2:0] raw);
    logic [2:0] s;
    s = raw;
    if (raw == 3'd0) begin
      s = 3'd1;
    end else if (raw > MAX_PIX_BYTES) begin
      s = MAX_PIX_BYTES;
    end
    return s;
  endfunction

endpackage

[hdl/tgarle_unpack.sv]
// Packet parser: header decode, pixel byte assembly and result formation.
module tgarle_unpack
  import tgarle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic [2:0] size,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic        raw_packet;
  logic [7:0]  remaining;
  logic [1:0]  byte_index;
  logic [31:0] assembly;

  logic        hdr_raw;
  logic [31:0] assembly_or;
  logic        last_byte;
  logic        pkt_end;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: begin
        if (accept) phase_next = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (accept && last_byte && pkt_end) phase_next = PH_HEADER;
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  always_comb begin
    hdr_raw     = in_byte < HDR_RAW_LIMIT;
    assembly_or = assembly | ({24'd0, in_byte} << {byte_index, 3'b000});
    last_byte   = ({1'b0, byte_index} + 3'd1) >= size;
    pkt_end     = raw_packet ? (remaining == 8'd1) : 1'b1;
    res_valid   = accept && (phase == PH_PIXEL) && last_byte;
    res.pixel_value  = assembly_or;
    res.repeat_count = raw_packet ? 8'd1 : remaining;
    res.packet_end   = pkt_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      raw_packet <= 1'b0;
      remaining  <= 8'd0;
      byte_index <= 2'd0;
      assembly   <= 32'd0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (phase == PH_HEADER) begin
          raw_packet <= hdr_raw;
          remaining  <= hdr_raw ? in_byte + 8'd1 : in_byte - REPEAT_BIAS;
          byte_index <= 2'd0;
          assembly   <= 32'd0;
        end else if (!last_byte) begin
          byte_index <= byte_index + 2'd1;
          assembly   <= assembly_or;
        end else begin
          remaining  <= raw_packet ? remaining - 8'd1 : 8'd0;
          byte_index <= 2'd0;
          assembly   <= 32'd0;
        end
      end
    end
  end

  a_no_result_on_header: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase == PH_PIXEL)
    else $error("result formed from a header byte");

  a_pixel_owed: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXEL |-> remaining != 8'd0)
    else $error("pixel phase with no pixels owed");

  a_end_to_header: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.packet_end |=> phase == PH_HEADER)
    else $error("packet end did not return to header");

endmodule

[hdl/tgarle_outq.sv]
// Two-entry result queue that decouples the parser from the output channel.
module tgarle_outq
  import tgarle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    not_full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;

  assign not_full  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt != 2'd2)
    else $error("result pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("queue count out of range");

endmodule

[hdl/tga_rle_packet_decoder_core.sv]
// Top level of the TGA run-length packet decoder.
//
// Input stream s_*: one byte of run-length encoded image data per item.
// Output stream m_*: one item per decoded pixel; tdata carries the pixel
// word (first stream byte in bits 7:0) and its repeat count, tlast marks
// the pixel that closes its packet. Header bytes and non-final pixel bytes
// give no output item. Repeat packets are not expanded here.
// APB register at byte address 0: pixel_bytes (bits 2:0), reset value 3.
//
// Throughput: one byte per cycle, sustained while the output queue has room.
// Each result is written into the output queue and drives m_tvalid from there.
// A two-entry output queue holds results while the receiver stalls; the
// input keeps flowing until both entries are occupied, then s_tready drops
// (it is decoded combinationally from the registered queue fill).
// Reset is synchronous: the parser returns to expecting a header byte, the
// output queue empties, and pixel_bytes returns to 3.
module tga_rle_packet_decoder_core
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] pixel_value, [39:32] repeat_count
  output logic        m_tlast,   // packet_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] pixel_bytes;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIXEL_BYTES) ? {29'd0, pixel_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes <= PIX_BYTES_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_BYTES) begin
      pixel_bytes <= pwdata[2:0];
    end
  end

  assign accept = s_tvalid && s_tready;

  tgarle_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .size      (eff_size(pixel_bytes)),
    .res_valid (res_valid),
    .res       (res)
  );

  tgarle_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .not_full  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.repeat_count, out_res.pixel_value};
  assign m_tlast = out_res.packet_end;

endmodule
